// ----- rtl/core/tirf_pkg.sv -----
`timescale 1ns / 1ps

package tirf_pkg;

	localparam logic [7:0] BYTE_IAC = 8'hFF;
	localparam logic [7:0] BYTE_NOP = 8'hF1;
	localparam logic [7:0] BYTE_SB  = 8'hFA;
	localparam logic [7:0] OPT_NAWS = 8'h1F;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_NUL = 8'h00;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_NAWS = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] win_cols;
		logic [15:0] win_rows;
	} tirf_res_t;

endpackage

// ----- rtl/core/tirf_parser.sv -----
`timescale 1ns / 1ps

module tirf_parser import tirf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte_s1,
	output logic       res_hit,
	output tirf_res_t  res
);

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_AFTER_CR,
		MODE_IAC,
		MODE_CMD_ARG,
		MODE_SB_OPT,
		MODE_SIZE,
		MODE_TRAIL1,
		MODE_TRAIL2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [31:0] acc_q, acc_d;

	always_comb begin
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		res_hit = 1'b0;
		res     = '0;
		case (mode_q)
			MODE_IAC: begin
				if (rx_byte_s1 == BYTE_NOP) begin
					mode_d = MODE_NORMAL;
				end else if (rx_byte_s1 == BYTE_IAC) begin
					mode_d         = MODE_NORMAL;
					res_hit        = 1'b1;
					res.kind       = KIND_DATA;
					res.data_byte  = BYTE_IAC;
				end else if (rx_byte_s1 == BYTE_SB) begin
					mode_d = MODE_SB_OPT;
				end else begin
					mode_d = MODE_CMD_ARG;
				end
			end
			MODE_CMD_ARG: begin
				mode_d = MODE_NORMAL;
			end
			MODE_SB_OPT: begin
				if (rx_byte_s1 == OPT_NAWS) begin
					mode_d = MODE_SIZE;
					cnt_d  = '0;
					acc_d  = '0;
				end else begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_SIZE: begin
				acc_d = {acc_q[23:0], rx_byte_s1};
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					mode_d = MODE_TRAIL1;
				end
			end
			MODE_TRAIL1: begin
				mode_d = MODE_TRAIL2;
			end
			MODE_TRAIL2: begin
				mode_d       = MODE_NORMAL;
				res_hit      = 1'b1;
				res.kind     = KIND_NAWS;
				res.win_cols = acc_q[31:16];
				res.win_rows = acc_q[15:0];
			end
			default: begin
				// normal data, or CR pending: LF/NUL after CR is swallowed
				if (mode_q == MODE_AFTER_CR &&
				    (rx_byte_s1 == BYTE_LF || rx_byte_s1 == BYTE_NUL)) begin
					mode_d = MODE_NORMAL;
				end else if (rx_byte_s1 == BYTE_IAC) begin
					mode_d = MODE_IAC;
				end else begin
					mode_d        = (rx_byte_s1 == BYTE_CR) ? MODE_AFTER_CR : MODE_NORMAL;
					res_hit       = 1'b1;
					res.kind      = KIND_DATA;
					res.data_byte = rx_byte_s1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
		end
	end

endmodule

// ----- rtl/core/tirf_out_reg.sv -----
`timescale 1ns / 1ps

module tirf_out_reg import tirf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  tirf_res_t res_d,
	output logic      slot_free,
	output logic      res_valid,
	input  logic      res_ready,
	output tirf_res_t res_q
);

	logic valid_q;

	assign slot_free = !valid_q || res_ready;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- rtl/core/telnet_iac_rx_filter_top.sv -----
`timescale 1ns / 1ps
// Telnet receive filter: strips IAC commands, swallows LF/NUL after CR, reports NAWS.
// Path: rx beat into the input register (rx_byte_s1), then any result into the result register (res_q).
// Throughput: one byte per cycle while the result side takes beats every cycle.
// Reset: arst_n asynchronous, active low; clears parse mode, size count/accumulator,
// and both valid flags.

module telnet_iac_rx_filter_top import tirf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [15:0] win_cols,
	output logic [15:0] win_rows
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       slot_free;
	logic       step;
	logic       res_hit;
	tirf_res_t  res_d;
	tirf_res_t  res_q;

	assign step     = valid_s1 && slot_free;
	assign rx_ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	tirf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte_s1 (rx_byte_s1),
		.res_hit    (res_hit),
		.res        (res_d)
	);

	tirf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && res_hit),
		.res_d     (res_d),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_q     (res_q)
	);

	assign kind      = res_q.kind;
	assign data_byte = res_q.data_byte;
	assign win_cols  = res_q.win_cols;
	assign win_rows  = res_q.win_rows;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import tirf_pkg::*;

	typedef enum logic [2:0] {
		PM_NORMAL,
		PM_AFTER_CR,
		PM_IAC,
		PM_CMD_ARG,
		PM_SB_OPT,
		PM_SIZE,
		PM_TRAIL1,
		PM_TRAIL2
	} parse_mode_t;

	typedef struct {
		logic [7:0] b;
		bit         drain_first;
	} rx_item_t;

	localparam logic [7:0] BYTE_SE   = 8'hF0;
	localparam logic [7:0] BYTE_WILL = 8'hFB;
	localparam int         CALM_TAIL = 150;
	localparam int         RX_TOTAL  = 1825;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [15:0] win_cols;
	logic [15:0] win_rows;

	rx_item_t    rx_stream[$];
	tirf_res_t   filtered_q[$];
	parse_mode_t mode = PM_NORMAL;
	logic [1:0]  size_cnt = 2'd0;
	logic [31:0] size_acc = 32'd0;
	int          errors = 0;
	int          rx_gap;
	int          res_gap;

	telnet_iac_rx_filter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.kind     (kind),
		.data_byte(data_byte),
		.win_cols (win_cols),
		.win_rows (win_rows)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("telnet_iac_rx_filter_top verification failed");
		$finish;
	end

	function automatic void queue_terminal_byte(input logic [7:0] b);
		tirf_res_t r;
		r.kind      = KIND_DATA;
		r.data_byte = b;
		r.win_cols  = 16'd0;
		r.win_rows  = 16'd0;
		filtered_q.push_back(r);
	endfunction

	function automatic void plain_byte_in(input logic [7:0] b);
		if (b == BYTE_IAC) begin
			mode = PM_IAC;
		end else begin
			mode = (b == BYTE_CR) ? PM_AFTER_CR : PM_NORMAL;
			queue_terminal_byte(b);
		end
	endfunction

	function automatic void filter_rx_byte(input logic [7:0] b);
		tirf_res_t r;
		case (mode)
			PM_AFTER_CR: begin
				if (b == BYTE_LF || b == BYTE_NUL)
					mode = PM_NORMAL;
				else
					plain_byte_in(b);
			end
			PM_IAC: begin
				if (b == BYTE_NOP) begin
					mode = PM_NORMAL;
				end else if (b == BYTE_IAC) begin
					mode = PM_NORMAL;
					queue_terminal_byte(BYTE_IAC);
				end else begin
					mode = (b == BYTE_SB) ? PM_SB_OPT : PM_CMD_ARG;
				end
			end
			PM_CMD_ARG: mode = PM_NORMAL;
			PM_SB_OPT: begin
				if (b == OPT_NAWS) begin
					mode = PM_SIZE;
					size_cnt = 2'd0;
					size_acc = 32'd0;
				end else begin
					mode = PM_NORMAL;
				end
			end
			PM_SIZE: begin
				size_acc = {size_acc[23:0], b};
				if (size_cnt == 2'd3)
					mode = PM_TRAIL1;
				size_cnt = size_cnt + 2'd1;
			end
			PM_TRAIL1: mode = PM_TRAIL2;
			PM_TRAIL2: begin
				mode = PM_NORMAL;
				r.kind      = KIND_NAWS;
				r.data_byte = 8'h00;
				r.win_cols  = size_acc[31:16];
				r.win_rows  = size_acc[15:0];
				filtered_q.push_back(r);
			end
			default: plain_byte_in(b);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (errors < 100)
			$display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic push_rx(input logic [7:0] b);
		rx_item_t it;
		it.b = b;
		it.drain_first = 1'b0;
		rx_stream.push_back(it);
	endtask

	function automatic bit idling_allowed();
		return rx_stream.size() > CALM_TAIL && (rx_stream.size() / 100) % 4 != 0;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte  <= 8'h00;
			rx_gap   <= 0;
		end else if (!rx_valid || rx_ready) begin
			if (rx_gap != 0) begin
				rx_valid <= 1'b0;
				rx_gap   <= rx_gap - 1;
			end else if (rx_stream.size() == 0 || (rx_stream[0].drain_first &&
					(rx_valid || filtered_q.size() != 0))) begin
				rx_valid <= 1'b0;
			end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
				rx_valid <= 1'b0;
				rx_gap   <= $urandom_range(0, 14);
			end else begin
				rx_byte  <= rx_stream[0].b;
				rx_valid <= 1'b1;
				void'(rx_stream.pop_front());
			end
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			res_gap   <= 0;
		end else if (res_gap != 0) begin
			res_ready <= 1'b0;
			res_gap   <= res_gap - 1;
		end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
			res_ready <= 1'b0;
			res_gap   <= $urandom_range(0, 14);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// monitor: predict on rx beat, check on result beat
	always @(posedge clk) begin
		tirf_res_t want;
		if (arst_n) begin
			if (rx_valid && rx_ready)
				filter_rx_byte(rx_byte);
			if (res_valid && res_ready) begin
				if (filtered_q.size() == 0) begin
					report_mismatch("unexpected result", {7'd0, kind, data_byte}, 16'd0);
				end else begin
					want = filtered_q.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", {15'd0, kind}, {15'd0, want.kind});
					if (data_byte !== want.data_byte)
						report_mismatch("data_byte", {8'd0, data_byte}, {8'd0, want.data_byte});
					if (win_cols !== want.win_cols)
						report_mismatch("win_cols", win_cols, want.win_cols);
					if (win_rows !== want.win_rows)
						report_mismatch("win_rows", win_rows, want.win_rows);
				end
			end
		end
	end

	initial begin
		static logic [7:0] directed [27] = '{
			BYTE_NUL,
			BYTE_CR, BYTE_NUL,
			BYTE_CR, BYTE_CR, BYTE_LF,
			BYTE_CR, BYTE_IAC, BYTE_NOP,
			BYTE_IAC, BYTE_IAC,
			BYTE_IAC, BYTE_SB, 8'h20, 8'h41,
			BYTE_IAC, BYTE_WILL, 8'h01,
			BYTE_IAC, BYTE_SB, OPT_NAWS, 8'hFF, 8'hFF, 8'h00, 8'h00, BYTE_IAC, BYTE_SE
		};
		int sel;
		int run;
		logic [7:0] opt;

		foreach (directed[i])
			push_rx(directed[i]);

		while (rx_stream.size() < RX_TOTAL) begin
			sel = $urandom_range(0, 19);
			if (sel <= 5) begin
				push_rx(8'($urandom_range(0, 255)));
			end else if (sel <= 7) begin
				push_rx(BYTE_CR);
				case ($urandom_range(0, 2))
					0: push_rx(BYTE_LF);
					1: push_rx(BYTE_NUL);
					default: push_rx(8'($urandom_range(0, 255)));
				endcase
			end else if (sel == 8) begin
				push_rx(BYTE_IAC);
				push_rx(BYTE_IAC);
			end else if (sel == 9) begin
				push_rx(BYTE_IAC);
				push_rx(BYTE_NOP);
			end else if (sel <= 11) begin
				push_rx(BYTE_IAC);
				push_rx(8'($urandom_range(0, 255)));
				push_rx(8'($urandom_range(0, 255)));
			end else if (sel <= 15) begin
				push_rx(BYTE_IAC);
				push_rx(BYTE_SB);
				push_rx(OPT_NAWS);
				repeat (4) begin
					if ($urandom_range(0, 3) == 0)
						push_rx($urandom_range(0, 1) ? 8'hFF : 8'h00);
					else
						push_rx(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 3) != 0) begin
					push_rx(BYTE_IAC);
					push_rx(BYTE_SE);
				end else begin
					push_rx(8'($urandom_range(0, 255)));
					push_rx(8'($urandom_range(0, 255)));
				end
			end else if (sel == 16) begin
				opt = 8'($urandom_range(0, 255));
				if (opt == OPT_NAWS)
					opt = 8'h18;
				push_rx(BYTE_IAC);
				push_rx(BYTE_SB);
				push_rx(opt);
				push_rx(8'($urandom_range(0, 254)));
			end else begin
				run = $urandom_range(1, 6);
				repeat (run)
					push_rx(8'($urandom_range(0, 254)));
			end
		end

		rx_stream[27].drain_first = 1'b1;
		rx_stream[rx_stream.size() / 2].drain_first = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_stream.size() != 0 || rx_valid)
			@(posedge clk);
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("telnet_iac_rx_filter_top verification clean");
		else
			$display("telnet_iac_rx_filter_top verification failed");
		$finish;
	end

endmodule
